// ----- sv/texture_store_bilinear_sampler_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the texture store sampler
// Implication checks, same-cycle and next-cycle, with a clock and reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_STORE_BILINEAR_SAMPLER_ASSERT_SVH
`define TEXTURE_STORE_BILINEAR_SAMPLER_ASSERT_SVH

// ante implies cons in the same cycle
`define TSBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define TSBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbs_pkg
// Shared types, codes and helpers of the texture store sampler.
// ----------------------------------------------------------------------------
package tsbs_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int COORD_FRAC_DEF = 8;
   localparam int DEPTH_DEF      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

   localparam int PIX_W    = 9;
   localparam int SAMPLE_W = 17;
   localparam int COLOR_W  = 16;
   localparam int CH_W     = 16;
   localparam int CFG_W    = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA    = 2'd2;

   localparam logic [PIX_W-1:0] DIM_RESET = 9'd256;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_POINT  = 2'd1;
   localparam logic [1:0] OP_FILTER = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [CH_W-1:0] FULL_SCALE = 16'hFF00;

   typedef struct packed {
      logic [1:0]          operation;
      logic [PIX_W-1:0]    pixel_x;
      logic [PIX_W-1:0]    pixel_y;
      logic [SAMPLE_W-1:0] sample_x;
      logic [SAMPLE_W-1:0] sample_y;
      logic [COLOR_W-1:0]  color_red;
      logic [COLOR_W-1:0]  color_green;
      logic [COLOR_W-1:0]  color_blue;
      logic [COLOR_W-1:0]  color_alpha;
   } tsbs_req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic [CH_W-1:0] out_alpha;
      logic            status;
   } tsbs_rsp_type;

   typedef struct packed {
      logic       rd;
      logic       wr;
      logic [3:0] be;
   } tsbs_mem_cmd_type;

   // Q4.12 to byte: min(floor(v*255/4096), 255)
   function automatic logic [7:0] to_byte(input logic [COLOR_W-1:0] v);
      logic [23:0] p;
      p = {v, 8'h00} - {8'h00, v};
      to_byte = (p[23:20] != 4'h0) ? 8'hFF : p[19:12];
   endfunction

endpackage

// ----- sv/tsbs_texmem.sv -----
// ----------------------------------------------------------------------------
// tsbs_texmem
// Single-port texel memory, 32-bit words with byte enables, registered read.
// ----------------------------------------------------------------------------
module tsbs_texmem
   import tsbs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  tsbs_mem_cmd_type cmd,
   input  logic [AW-1:0]    addr,
   input  logic [31:0]      wdata,
   output logic [31:0]      rdata
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         for (int b = 0; b < 4; b++) begin
            if (cmd.be[b]) begin
               mem_ff[addr][8*b +: 8] <= wdata[8*b +: 8];
            end
         end
      end
      if (cmd.rd) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/tsbs_blend.sv -----
// ----------------------------------------------------------------------------
// tsbs_blend
// Bilinear blend of four texels: horizontal lerp, vertical lerp, saturate.
// ----------------------------------------------------------------------------
module tsbs_blend
   import tsbs_pkg::*;
#(
   parameter int FRAC = COORD_FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [3:0][31:0]       texel,
   input  logic                   has_alpha,
   input  logic signed [FRAC:0]   frac_x,
   input  logic signed [FRAC:0]   frac_y,
   output logic                   out_valid,
   output logic [3:0][CH_W-1:0]   out_ch
);

   localparam int WW    = FRAC + 2;
   localparam int BW    = 9;
   localparam int HW    = BW + WW + 1;
   localparam int SW    = HW + WW + 1;
   localparam int SHIFT = 2 * FRAC - 8;
   localparam int VW    = SW - SHIFT;
   localparam logic signed [WW-1:0] ONE_W  = WW'(1 << FRAC);
   localparam logic signed [VW-1:0] FULL_V = VW'(FULL_SCALE);

   logic signed [BW-1:0] sb [4][4];
   logic signed [WW-1:0] wx0, wx1, wy0_in, wy1_in;
   logic signed [HW-1:0] top_in [4];
   logic signed [HW-1:0] bot_in [4];
   logic signed [SW-1:0] sum_in [4];
   logic signed [SW-1:0] sh     [4];
   logic [3:0][CH_W-1:0] ch_in;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [HW-1:0] top_ff [4];
   logic signed [HW-1:0] bot_ff [4];
   logic signed [WW-1:0] wy0_ff, wy1_ff;
   logic signed [SW-1:0] sum_ff [4];
   logic [3:0][CH_W-1:0] out_ch_ff;

   assign wx1    = WW'(frac_x);
   assign wx0    = ONE_W - wx1;
   assign wy1_in = WW'(frac_y);
   assign wy0_in = ONE_W - wy1_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            if (c == 3 && !has_alpha) begin
               sb[c][k] = $signed({1'b0, 8'hFF});
            end else begin
               sb[c][k] = $signed({1'b0, texel[k][8*c +: 8]});
            end
         end
         top_in[c] = sb[c][0] * wx0 + sb[c][1] * wx1;
         bot_in[c] = sb[c][2] * wx0 + sb[c][3] * wx1;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = top_ff[c] * wy0_ff + bot_ff[c] * wy1_ff;
      end
   end

   // floor divide by one^2 with the byte-to-16-bit scale folded in
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sh[c] = sum_ff[c] >>> SHIFT;
         if (sh[c][VW-1]) begin
            ch_in[c] = '0;
         end else if (sh[c][VW-1:0] > FULL_V) begin
            ch_in[c] = FULL_SCALE;
         end else begin
            ch_in[c] = sh[c][CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         wy0_ff <= wy0_in;
         wy1_ff <= wy1_in;
      end
      if (v1_ff) begin
         sum_ff <= sum_in;
      end
      if (v2_ff) begin
         out_ch_ff <= ch_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_ch    = out_ch_ff;

endmodule

// ----- sv/texture_store_bilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// texture_store_bilinear_sampler
// Texture store with pixel writes, point reads and bilinear filtered reads.
//
//   channel  ports                         direction  handshake
//   request  start, busy, req_data         in         start && !busy
//   result   rsp_valid, rsp_data           out        rsp_valid, one cycle
//   config   csr_we, csr_index, csr_wdata  in         csr_we
//
// From prep a rejected write or unused code answers, a write goes to the
// write state, and a read through fetch, drain, launch and the three-stage
// blend; a filtered read fetches four texels through the single memory
// port. One item at a time; the next beat may be taken during the strobe.
// After reset the store is cleared one word a cycle, MAX_WIDTH*MAX_HEIGHT
// words, with busy high. The result beat cannot be stalled.
// ----------------------------------------------------------------------------
`include "texture_store_bilinear_sampler_assert.svh"

module texture_store_bilinear_sampler
   import tsbs_pkg::*;
#(
   parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tsbs_req_type         req_data,
   output logic                 rsp_valid,
   output tsbs_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int FRAC   = COORD_FRAC_BITS;
   localparam int HALF   = 1 << (FRAC - 1);
   localparam int IW     = SAMPLE_W - FRAC;
   localparam int CW     = (IW + 1 > PIX_W) ? IW + 1 : PIX_W;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int ROW_W  = 2 * PIX_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PREP, ST_FETCH, ST_DRAIN, ST_LAUNCH, ST_BLEND, ST_WRITE
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tsbs_rsp_type         rsp_ff, rsp_in;
   logic [AW-1:0]        clr_ff;
   logic [1:0]           fidx_ff, last_ff, rd_idx_ff;
   logic                 rd_pend_ff, single_ff;

   logic [PIX_W-1:0]     width_ff, height_ff;
   logic                 alpha_ff;
   logic [PIX_W-1:0]     w_eff, h_eff;

   tsbs_req_type         req_ff;
   logic [PIX_W-1:0]     x0_ff, x1_ff, yf0_ff, yf1_ff;
   logic signed [FRAC:0] fx_ff, fy_ff;
   logic [31:0]          color_ff;
   logic [3:0][31:0]     nb_ff;

   logic                 is_filter, wr_ok;
   logic [SAMPLE_W-1:0]  samp [2];
   logic [PIX_W-1:0]     pix  [2];
   logic [PIX_W-1:0]     dm1  [2];
   logic [DIFF_W-1:0]    diff [2];
   logic [CW-1:0]        c0   [2];
   logic [CW-1:0]        c1   [2];
   logic [PIX_W-1:0]     k0   [2];
   logic [PIX_W-1:0]     k1   [2];
   logic signed [FRAC:0] frac [2];

   logic [PIX_W-1:0]     yrow, xcol;
   logic [ROW_W-1:0]     row_prod, addr_sum;
   logic [AW-1:0]        mem_addr;
   tsbs_mem_cmd_type     mem_cmd;
   logic [31:0]          mem_wdata, mem_q;

   logic                 bl_valid;
   logic [3:0][CH_W-1:0] bl_ch;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         alpha_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_HAS_ALPHA:    alpha_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = PIX_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = PIX_W'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = PIX_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = PIX_W'(MAX_HEIGHT);
      end
   end

   // Coordinate split and clamp, x in lane 0 and y in lane 1
   assign is_filter = (req_ff.operation == OP_FILTER);
   assign samp[0]   = req_ff.sample_x;
   assign samp[1]   = req_ff.sample_y;
   assign pix[0]    = req_ff.pixel_x;
   assign pix[1]    = req_ff.pixel_y;
   assign dm1[0]    = w_eff - PIX_W'(1);
   assign dm1[1]    = h_eff - PIX_W'(1);
   assign wr_ok     = (req_ff.pixel_x < w_eff) && (req_ff.pixel_y < h_eff);

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         diff[a] = {1'b0, samp[a]} - DIFF_W'(HALF);
         if (is_filter) begin
            if (diff[a][DIFF_W-1]) begin
               c0[a]   = '0;
               frac[a] = $signed(diff[a][FRAC:0]);
            end else begin
               c0[a]   = CW'(diff[a][SAMPLE_W-1:FRAC]);
               frac[a] = $signed({1'b0, diff[a][FRAC-1:0]});
            end
            c1[a] = c0[a] + CW'(1);
         end else begin
            c0[a]   = CW'(pix[a]);
            c1[a]   = CW'(pix[a]);
            frac[a] = '0;
         end
         k0[a] = (c0[a] > CW'(dm1[a])) ? dm1[a] : c0[a][PIX_W-1:0];
         k1[a] = (c1[a] > CW'(dm1[a])) ? dm1[a] : c1[a][PIX_W-1:0];
      end
   end

   // Texel address: bottom-up rows
   assign yrow     = fidx_ff[1] ? yf1_ff : yf0_ff;
   assign xcol     = fidx_ff[0] ? x1_ff : x0_ff;
   assign row_prod = yrow * w_eff;
   assign addr_sum = row_prod + ROW_W'(xcol);
   assign mem_addr = (state_ff == ST_CLEAR) ? clr_ff : AW'(addr_sum);

   always_comb begin
      mem_cmd.rd = (state_ff == ST_FETCH);
      mem_cmd.wr = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      mem_cmd.be = (state_ff == ST_CLEAR) ? 4'hF : {alpha_ff, 3'b111};
      mem_wdata  = (state_ff == ST_CLEAR) ? 32'h0 : color_ff;
   end

   tsbs_texmem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_texmem (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_q)
   );

   tsbs_blend #(
      .FRAC (FRAC)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == ST_LAUNCH),
      .texel     (nb_ff),
      .has_alpha (alpha_ff),
      .frac_x    (fx_ff),
      .frac_y    (fy_ff),
      .out_valid (bl_valid),
      .out_ch    (bl_ch)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            unique case (req_ff.operation) inside
               OP_WRITE: begin
                  if (wr_ok) begin
                     state_in = ST_WRITE;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               OP_POINT, OP_FILTER: state_in = ST_FETCH;
               OP_NOP: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_FETCH: begin
            if (fidx_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_BLEND;
         ST_BLEND: begin
            if (bl_valid) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_red   = bl_ch[0];
               rsp_in.out_green = bl_ch[1];
               rsp_in.out_blue  = bl_ch[2];
               rsp_in.out_alpha = bl_ch[3];
               state_in         = ST_IDLE;
            end
         end
         ST_WRITE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         fidx_ff      <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_valid_in) begin
            rsp_ff <= rsp_in;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_PREP) begin
            fidx_ff <= '0;
         end else if (state_ff == ST_FETCH) begin
            fidx_ff <= fidx_ff + 2'd1;
         end
         rd_pend_ff <= (state_ff == ST_FETCH);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_PREP) begin
         x0_ff     <= k0[0];
         x1_ff     <= k1[0];
         yf0_ff    <= dm1[1] - k0[1];
         yf1_ff    <= dm1[1] - k1[1];
         fx_ff     <= frac[0];
         fy_ff     <= frac[1];
         last_ff   <= is_filter ? 2'd3 : 2'd0;
         single_ff <= !is_filter;
         color_ff  <= {to_byte(req_ff.color_alpha), to_byte(req_ff.color_blue),
                       to_byte(req_ff.color_green), to_byte(req_ff.color_red)};
      end
      rd_idx_ff <= fidx_ff;
      if (rd_pend_ff) begin
         if (single_ff) begin
            nb_ff <= {4{mem_q}};
         end else begin
            nb_ff[rd_idx_ff] <= mem_q;
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TSBS_ASSERT_NEXT(a_rsp_one_beat, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")
   `TSBS_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `TSBS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `TSBS_ASSERT_IMPLY(a_mem_wr_state, clock, reset, mem_cmd.wr,
      (state_ff == ST_WRITE) || (state_ff == ST_CLEAR), "stray memory write")
   `TSBS_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_valid && rsp_data.status,
      (rsp_data.out_red == '0) && (rsp_data.out_alpha == '0), "rejected write with color")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - texture_store_bilinear_sampler
// Drives pixel writes, point reads and filtered reads through the command port
// and predicts every result beat from a local texture store and local copies of
// the image registers. Each beat is compared field by field. A short directed
// table covers the extremes, then random traffic runs under a series of image
// sizes and alpha settings, written between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import tsbs_pkg::*;

   localparam int     ITEMS_PER_PHASE = 150;
   localparam int     PHASE_COUNT     = 9;
   localparam int     WATCHDOG_LIMIT  = 4 * DEPTH_DEF;
   localparam longint FRAC_ONE        = longint'(1) << COORD_FRAC_DEF;

   typedef longint quad_type [4];

   typedef struct {
      tsbs_req_type req;
      bit           typed;
      tsbs_rsp_type rsp;
   } probe_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   tsbs_req_type         req_data;
   logic                 rsp_valid;
   tsbs_rsp_type         rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   logic [31:0]      texel_mem [DEPTH_DEF];
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic             cfg_alpha;

   tsbs_rsp_type due_samples_q [$];
   probe_type    probe_rows [$];
   int           mismatches;
   int           idle_cycles = 0;
   int           calm_left;
   int           win_x;
   int           win_y;

   logic [CFG_W-1:0] phase_width [PHASE_COUNT] =
      '{9'd256, 9'd1, 9'd0, 9'd16, 9'd511, 9'd3, 9'd100, 9'd7, 9'd256};
   logic [CFG_W-1:0] phase_height [PHASE_COUNT] =
      '{9'd256, 9'd1, 9'd0, 9'd8, 9'd300, 9'd200, 9'd1, 9'd5, 9'd256};
   logic phase_alpha [PHASE_COUNT] =
      '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   texture_store_bilinear_sampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int dim_of(input logic [CFG_W-1:0] v, input int cap);
      int d;
      d = int'(v);
      if (d == 0) d = 1;
      if (d > cap) d = cap;
      return d;
   endfunction

   function automatic logic [7:0] byte_of(input logic [COLOR_W-1:0] v);
      logic [23:0] q;
      q = ({8'd0, v} * 24'd255) >> 12;
      return (q > 24'd255) ? 8'hFF : q[7:0];
   endfunction

   function automatic void texel_fetch(input int x, input int y, output quad_type ch);
      int          w;
      int          h;
      logic [31:0] word;
      w = dim_of(cfg_width, MAX_WIDTH_DEF);
      h = dim_of(cfg_height, MAX_HEIGHT_DEF);
      if (x > w - 1) x = w - 1;
      if (y > h - 1) y = h - 1;
      word = texel_mem[(h - 1 - y) * w + x];
      for (int i = 0; i < 4; i++) ch[i] = longint'(word[8*i +: 8]) * 256;
      if (!cfg_alpha) ch[3] = longint'(FULL_SCALE);
   endfunction

   // sample - 1/2, integer part toward zero, fraction may go negative
   function automatic void split_sample(input logic [SAMPLE_W-1:0] s, output int ip,
                                        output longint fr);
      longint c;
      c  = longint'(s) - FRAC_ONE / 2;
      ip = (c >= 0) ? int'(c / FRAC_ONE) : 0;
      fr = c - longint'(ip) * FRAC_ONE;
   endfunction

   function automatic tsbs_rsp_type predict_sample(input tsbs_req_type r);
      tsbs_rsp_type o;
      int           w;
      int           h;
      int           idx;
      int           xi;
      int           yi;
      longint       fx;
      longint       fy;
      longint       top;
      longint       bot;
      quad_type     tl;
      quad_type     tr;
      quad_type     bl;
      quad_type     br;
      quad_type     mix;
      o   = '0;
      mix = '{default: 0};
      w   = dim_of(cfg_width, MAX_WIDTH_DEF);
      h   = dim_of(cfg_height, MAX_HEIGHT_DEF);
      case (r.operation)
         OP_WRITE: begin
            if (int'(r.pixel_x) >= w || int'(r.pixel_y) >= h) begin
               o.status = 1'b1;
            end else begin
               idx = (h - 1 - int'(r.pixel_y)) * w + int'(r.pixel_x);
               texel_mem[idx][7:0]   = byte_of(r.color_red);
               texel_mem[idx][15:8]  = byte_of(r.color_green);
               texel_mem[idx][23:16] = byte_of(r.color_blue);
               if (cfg_alpha) texel_mem[idx][31:24] = byte_of(r.color_alpha);
            end
         end
         OP_POINT: begin
            texel_fetch(int'(r.pixel_x), int'(r.pixel_y), mix);
         end
         OP_FILTER: begin
            split_sample(r.sample_x, xi, fx);
            split_sample(r.sample_y, yi, fy);
            texel_fetch(xi, yi, tl);
            texel_fetch(xi + 1, yi, tr);
            texel_fetch(xi, yi + 1, bl);
            texel_fetch(xi + 1, yi + 1, br);
            for (int i = 0; i < 4; i++) begin
               top    = tl[i] * (FRAC_ONE - fx) + tr[i] * fx;
               bot    = bl[i] * (FRAC_ONE - fx) + br[i] * fx;
               mix[i] = (top * (FRAC_ONE - fy) + bot * fy) >>> (2 * COORD_FRAC_DEF);
               if (mix[i] < 0) mix[i] = 0;
               if (mix[i] > longint'(FULL_SCALE)) mix[i] = longint'(FULL_SCALE);
            end
         end
         default: ;
      endcase
      o.out_red   = CH_W'(mix[0]);
      o.out_green = CH_W'(mix[1]);
      o.out_blue  = CH_W'(mix[2]);
      o.out_alpha = CH_W'(mix[3]);
      return o;
   endfunction

   function automatic tsbs_req_type mk_req(input logic [1:0] op,
                                           input logic [PIX_W-1:0] px, py,
                                           input logic [SAMPLE_W-1:0] sx, sy,
                                           input logic [COLOR_W-1:0] r, g, b, a);
      tsbs_req_type q;
      q.operation   = op;
      q.pixel_x     = px;
      q.pixel_y     = py;
      q.sample_x    = sx;
      q.sample_y    = sy;
      q.color_red   = r;
      q.color_green = g;
      q.color_blue  = b;
      q.color_alpha = a;
      return q;
   endfunction

   function automatic tsbs_rsp_type mk_rsp(input logic [CH_W-1:0] r, g, b, a,
                                           input logic st);
      tsbs_rsp_type q;
      q.out_red   = r;
      q.out_green = g;
      q.out_blue  = b;
      q.out_alpha = a;
      q.status    = st;
      return q;
   endfunction

   function automatic logic [PIX_W-1:0] pick_coord(input int dim, input int origin);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = origin + $urandom_range(0, (dim > 6) ? 5 : dim - 1);
         6:                v = 0;
         7:                v = dim - 1 + $urandom_range(0, 1);
         8:                v = $urandom_range(0, dim - 1);
         default:          v = $urandom_range(0, 511);
      endcase
      return PIX_W'(v);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int dim, input int origin);
      logic [7:0] frac;
      frac = ($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom);
      return {pick_coord(dim, origin), frac};
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return COLOR_W'($urandom_range(0, 16'h1000));
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   function automatic tsbs_req_type rand_req();
      tsbs_req_type r;
      int           w;
      int           h;
      int           pick;
      w    = dim_of(cfg_width, MAX_WIDTH_DEF);
      h    = dim_of(cfg_height, MAX_HEIGHT_DEF);
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.operation = OP_WRITE;
      else if (pick < 60) r.operation = OP_POINT;
      else if (pick < 95) r.operation = OP_FILTER;
      else                r.operation = OP_NOP;
      r.pixel_x     = pick_coord(w, win_x);
      r.pixel_y     = pick_coord(h, win_y);
      r.sample_x    = pick_sample(w, win_x);
      r.sample_y    = pick_sample(h, win_y);
      r.color_red   = pick_color();
      r.color_green = pick_color();
      r.color_blue  = pick_color();
      r.color_alpha = pick_color();
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [CH_W-1:0] want,
                                input logic [CH_W-1:0] got);
      if (mismatches < 100)
         $display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   // leaves start high on return, so a beat can follow back to back
   task automatic issue(input tsbs_req_type item, input bit typed,
                        input tsbs_rsp_type typed_rsp);
      int           gap;
      tsbs_rsp_type predicted;
      if (calm_left != 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         calm_left = 30;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 14);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_sample(item);
      due_samples_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (due_samples_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic a);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      cfg_width = w;
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      cfg_height = h;
      csr_index <= CSR_HAS_ALPHA;
      csr_wdata <= {8'($urandom), a};
      @(posedge clock);
      cfg_alpha = a;
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : beat_check
      tsbs_rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_samples_q.size() == 0) begin
            flag_mismatch("result beat with nothing outstanding", '0, '0);
         end else begin
            want = due_samples_q.pop_front();
            if (rsp_data.out_red !== want.out_red)
               flag_mismatch("out_red", want.out_red, rsp_data.out_red);
            if (rsp_data.out_green !== want.out_green)
               flag_mismatch("out_green", want.out_green, rsp_data.out_green);
            if (rsp_data.out_blue !== want.out_blue)
               flag_mismatch("out_blue", want.out_blue, rsp_data.out_blue);
            if (rsp_data.out_alpha !== want.out_alpha)
               flag_mismatch("out_alpha", want.out_alpha, rsp_data.out_alpha);
            if (rsp_data.status !== want.status)
               flag_mismatch("status", CH_W'(want.status), CH_W'(rsp_data.status));
         end
      end
   end

   // store clear after reset is the longest quiet stretch
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL texture_store_bilinear_sampler");
            $finish;
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      mismatches  = 0;
      calm_left   = 0;
      win_x       = 0;
      win_y       = 0;
      cfg_width   = DIM_RESET;
      cfg_height  = DIM_RESET;
      cfg_alpha   = 1'b0;
      for (int i = 0; i < DEPTH_DEF; i++) texel_mem[i] = '0;

      // fresh store, 256 x 256, alpha off
      probe_rows.push_back('{mk_req(OP_POINT, 9'd0, 9'd0, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, FULL_SCALE, 1'b0)});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd511, 9'd511, 17'h1FFFF, 17'h1FFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, FULL_SCALE, 1'b0)});
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, FULL_SCALE, 1'b0)});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd0, 9'd0, 17'h0, 17'h0,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b0)});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd0, 9'd0, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_rsp(16'hFF00, 16'hFF00, 16'hFF00, FULL_SCALE, 1'b0)});
      // writes outside the image
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd256, 9'd0, 17'h0, 17'h0,
                                    16'h1000, 16'h1000, 16'h1000, 16'h1000),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b1)});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd0, 9'd256, 17'h0, 17'h0,
                                    16'h1000, 16'h1000, 16'h1000, 16'h1000),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b1)});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd511, 9'd511, 17'h1FFFF, 17'h1FFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b1)});
      // far corner, alpha write dropped while alpha is off
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd255, 9'd255, 17'h0, 17'h0,
                                    16'h1000, 16'h0800, 16'h0000, 16'hFFFF),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b0)});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd255, 9'd255, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_rsp(16'hFF00, 16'h7F00, 16'h0, FULL_SCALE, 1'b0)});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd300, 9'd400, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_rsp(16'hFF00, 16'h7F00, 16'h0, FULL_SCALE, 1'b0)});
      probe_rows.push_back('{mk_req(OP_NOP, 9'd511, 9'd511, 17'h1FFFF, 17'h1FFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b1, mk_rsp(16'h0, 16'h0, 16'h0, 16'h0, 1'b0)});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd1, 9'd0, 17'h0, 17'h0,
                                    16'h0FFF, 16'h1001, 16'h8000, 16'h0000), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd0, 9'd1, 17'h0, 17'h0,
                                    16'h0001, 16'h0FF0, 16'h1234, 16'hABCD), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_WRITE, 9'd1, 9'd1, 17'h0, 17'h0,
                                    16'h0800, 16'h0400, 16'h0C00, 16'h0000), 1'b0, '0});
      // negative fraction, mixed fractions, exact texel centers
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h0C0, 17'h0A0,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h080, 17'h180,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h1FFFF, 17'h1FFFF,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_FILTER, 9'd0, 9'd0, 17'h0FF80, 17'h0FF40,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd1, 9'd1, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});
      probe_rows.push_back('{mk_req(OP_POINT, 9'd0, 9'd1, 17'h0, 17'h0,
                                    16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      foreach (probe_rows[i]) issue(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].rsp);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         apply_setting(phase_width[ph], phase_height[ph], phase_alpha[ph]);
         win_x = $urandom_range(0, (dim_of(cfg_width, MAX_WIDTH_DEF) > 6) ?
                                   dim_of(cfg_width, MAX_WIDTH_DEF) - 6 : 0);
         win_y = $urandom_range(0, (dim_of(cfg_height, MAX_HEIGHT_DEF) > 6) ?
                                   dim_of(cfg_height, MAX_HEIGHT_DEF) - 6 : 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 59) == 0) settle();
            issue(rand_req(), 1'b0, '0);
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS texture_store_bilinear_sampler");
      end else begin
         $display("FAIL texture_store_bilinear_sampler");
      end
      $finish;
   end

endmodule
